/* rtl/kendall_tau_rank_scorer_macros.svh */
// ----------------------------------------------------------------------------
// Kendall tau rank scorer assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KENDALL_TAU_RANK_SCORER_MACROS_SVH
`define KENDALL_TAU_RANK_SCORER_MACROS_SVH

`ifndef SYNTHESIS
`define KTRS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define KTRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define KTRS_ASSERT_IMPL(label, ante, cons)
`define KTRS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/ktrs_pkg.sv */
// ----------------------------------------------------------------------------
// Kendall tau rank scorer package
// Widths, opcodes and default parameter values shared by the scorer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ktrs_pkg;

	localparam int RANK_FIELDS = 8;
	localparam int RANK_W = 3;
	localparam int ORDER_W = RANK_FIELDS * RANK_W;
	localparam int CNT_W = 4;
	localparam int DISCORD_W = 5;
	localparam int SUM_W = 25;
	localparam int TALLY_W = 20;
	localparam int OUT_W = DISCORD_W + SUM_W + TALLY_W + 1 + ORDER_W + SUM_W + TALLY_W;

	localparam int MAX_ITEMS_DEF = 8;
	localparam int VOTER_COUNT_BITS_DEF = 20;

	localparam logic [CNT_W-1:0] ITEM_COUNT_RESET = 4'd5;

	typedef logic [1:0] opcode_t;

	localparam opcode_t OP_LOAD = 2'd0;
	localparam opcode_t OP_VOTER = 2'd1;
	localparam opcode_t OP_END_PASS = 2'd2;
	localparam opcode_t OP_CLEAR_BEST = 2'd3;

endpackage

`default_nettype wire

/* rtl/ktrs_discord.sv */
// ----------------------------------------------------------------------------
// Kendall tau discordant pair counter
// Counts the item pairs that a voter ranking orders opposite to the candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module ktrs_discord #(
	parameter int MAX_ITEMS = ktrs_pkg::MAX_ITEMS_DEF
) (
	input  wire logic [ktrs_pkg::CNT_W-1:0]     n_items,
	input  wire logic [ktrs_pkg::ORDER_W-1:0]   cand_order,
	input  wire logic [ktrs_pkg::ORDER_W-1:0]   voter_order,
	output logic      [ktrs_pkg::DISCORD_W-1:0] discord
);

	localparam int POS_W = $clog2(MAX_ITEMS + 1);
	localparam int MAX_PAIRS = MAX_ITEMS * (MAX_ITEMS - 1) / 2;
	localparam int RW = ktrs_pkg::RANK_W;

	logic [RW-1:0]    cand [MAX_ITEMS];
	logic [RW-1:0]    voter [MAX_ITEMS];
	logic [POS_W-1:0] cand_pos [MAX_ITEMS];
	logic [POS_W-1:0] voter_pos [MAX_ITEMS];
	logic [POS_W-1:0] n_pos;
	logic [MAX_PAIRS-1:0] pair_bits;

	assign n_pos = POS_W'(n_items);

	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			cand[i] = cand_order[RW*i +: RW];
			voter[i] = voter_order[RW*i +: RW];
		end
	end

	// An item's position is the highest position below n holding it, n when absent.
	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			cand_pos[i] = n_pos;
			voter_pos[i] = n_pos;
			for (int p = 0; p < MAX_ITEMS; p++) begin
				if (POS_W'(p) < n_pos) begin
					if (cand[p] == cand[i]) begin
						cand_pos[i] = POS_W'(p);
					end
					if (voter[p] == cand[i]) begin
						voter_pos[i] = POS_W'(p);
					end
				end
			end
		end
	end

	always_comb begin
		int k;
		k = 0;
		pair_bits = '0;
		for (int i = 0; i < MAX_ITEMS - 1; i++) begin
			for (int j = i + 1; j < MAX_ITEMS; j++) begin
				pair_bits[k] = (POS_W'(j) < n_pos) &&
					(((cand_pos[i] < cand_pos[j]) && (voter_pos[i] > voter_pos[j])) ||
					 ((cand_pos[i] > cand_pos[j]) && (voter_pos[i] < voter_pos[j])));
				k++;
			end
		end
	end

	assign discord = ktrs_pkg::DISCORD_W'($countones(pair_bits));

endmodule

`default_nettype wire

/* rtl/kendall_tau_rank_scorer.sv */
// The input word is registered in stage s1 and its result word in the output register.
// Throughput: one word per cycle while the output is not stalled, which holds stage s1;
// the discordant pair count and the accumulator update sit in one stage between the input
// register and the result register.
// Reset (arst_n low, asynchronous) empties both stages, sets item_count to five and
// clears the candidate, the running sums and the held best.
// ----------------------------------------------------------------------------
// Kendall tau rank scorer
// Scores voter rankings against a candidate and keeps the best candidate.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kendall_tau_rank_scorer_macros.svh"

module kendall_tau_rank_scorer #(
	parameter int MAX_ITEMS = ktrs_pkg::MAX_ITEMS_DEF,
	parameter int VOTER_COUNT_BITS = ktrs_pkg::VOTER_COUNT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [ktrs_pkg::CNT_W-1:0]   cfg_wr_data,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// rank_pos0 .. rank_pos7, three bits each.
	input  wire logic [ktrs_pkg::ORDER_W-1:0] s_axis_tdata,
	// opcode.
	input  wire logic [1:0]                   s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// pair_discord, pass_discord_total, pass_voters, became_best, best_order,
	// best_discord_total, best_voters.
	output logic [ktrs_pkg::OUT_W-1:0]        m_axis_tdata
);

	localparam int CNT_W = ktrs_pkg::CNT_W;
	localparam int SUM_W = ktrs_pkg::SUM_W;
	localparam int TALLY_W = ktrs_pkg::TALLY_W;
	localparam int ORDER_W = ktrs_pkg::ORDER_W;
	localparam int RW = ktrs_pkg::RANK_W;
	localparam int DISCORD_W = ktrs_pkg::DISCORD_W;
	localparam int PROD_W = SUM_W + TALLY_W;
	localparam int MAX_PAIRS = MAX_ITEMS * (MAX_ITEMS - 1) / 2;
	localparam logic [TALLY_W-1:0] TALLY_CAP = (VOTER_COUNT_BITS >= TALLY_W) ? '1 :
		TALLY_W'((64'd1 << VOTER_COUNT_BITS) - 64'd1);
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	logic [CNT_W-1:0]     item_count_q;
	logic                 valid_s1;
	ktrs_pkg::opcode_t    op_s1;
	logic [ORDER_W-1:0]   ranks_s1;
	logic                 out_valid_q;
	logic [ktrs_pkg::OUT_W-1:0] out_data_q;

	logic [ORDER_W-1:0]   cand_order_q;
	logic [SUM_W-1:0]     sum_q;
	logic [TALLY_W-1:0]   tally_q;
	logic                 best_held_q;
	logic [ORDER_W-1:0]   best_order_q;
	logic [SUM_W-1:0]     best_sum_q;
	logic [TALLY_W-1:0]   best_tally_q;

	logic                 advance;
	logic                 fire;
	logic [CNT_W-1:0]     n_act;
	logic [DISCORD_W-1:0] discord;
	logic [ORDER_W-1:0]   load_order;
	logic [SUM_W:0]       sum_add;
	logic [PROD_W-1:0]    lhs_prod;
	logic [PROD_W-1:0]    rhs_prod;
	logic                 wins;

	logic [ORDER_W-1:0]   cand_nx;
	logic [SUM_W-1:0]     sum_nx;
	logic [TALLY_W-1:0]   tally_nx;
	logic                 best_held_nx;
	logic [ORDER_W-1:0]   best_order_nx;
	logic [SUM_W-1:0]     best_sum_nx;
	logic [TALLY_W-1:0]   best_tally_nx;
	logic                 won;
	logic [DISCORD_W-1:0] discord_out;

	assign advance = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign fire = valid_s1 && advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	assign n_act = (item_count_q > CNT_W'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : item_count_q;

	ktrs_discord #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_discord (
		.n_items(n_act),
		.cand_order(cand_order_q),
		.voter_order(ranks_s1),
		.discord(discord)
	);

	always_comb begin
		for (int i = 0; i < ktrs_pkg::RANK_FIELDS; i++) begin
			load_order[RW*i +: RW] = (CNT_W'(i) < n_act) ? ranks_s1[RW*i +: RW] : '0;
		end
	end

	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(discord);
	assign lhs_prod = PROD_W'(sum_q) * PROD_W'(best_tally_q);
	assign rhs_prod = PROD_W'(best_sum_q) * PROD_W'(tally_q);
	assign wins = (tally_q != '0) && (!best_held_q || (lhs_prod < rhs_prod));

	always_comb begin
		cand_nx = cand_order_q;
		sum_nx = sum_q;
		tally_nx = tally_q;
		best_held_nx = best_held_q;
		best_order_nx = best_order_q;
		best_sum_nx = best_sum_q;
		best_tally_nx = best_tally_q;
		won = 1'b0;
		discord_out = '0;
		case (op_s1)
			ktrs_pkg::OP_LOAD: begin
				cand_nx = load_order;
				sum_nx = '0;
				tally_nx = '0;
			end
			ktrs_pkg::OP_VOTER: begin
				discord_out = discord;
				if (tally_q < TALLY_CAP) begin
					tally_nx = tally_q + TALLY_W'(1);
					sum_nx = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
				end
			end
			ktrs_pkg::OP_END_PASS: begin
				if (wins) begin
					best_held_nx = 1'b1;
					best_order_nx = cand_order_q;
					best_sum_nx = sum_q;
					best_tally_nx = tally_q;
					won = 1'b1;
				end
			end
			default: begin
				best_held_nx = 1'b0;
				best_order_nx = '0;
				best_sum_nx = '0;
				best_tally_nx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= ktrs_pkg::ITEM_COUNT_RESET;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			cand_order_q <= '0;
			sum_q <= '0;
			tally_q <= '0;
			best_held_q <= 1'b0;
			best_order_q <= '0;
			best_sum_q <= '0;
			best_tally_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				item_count_q <= cfg_wr_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				cand_order_q <= cand_nx;
				sum_q <= sum_nx;
				tally_q <= tally_nx;
				best_held_q <= best_held_nx;
				best_order_q <= best_order_nx;
				best_sum_q <= best_sum_nx;
				best_tally_q <= best_tally_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1 <= s_axis_tuser;
			ranks_s1 <= s_axis_tdata;
		end
		if (fire) begin
			out_data_q <= {best_tally_nx, best_sum_nx, best_order_nx, won,
				tally_nx, sum_nx, discord_out};
		end
	end

	`KTRS_ASSERT_IMPL(a_best_held_tally, 1'b1, best_held_q == (best_tally_q != '0))
	`KTRS_ASSERT_IMPL(a_tally_capped, 1'b1,
		(tally_q <= TALLY_CAP) && (best_tally_q <= TALLY_CAP))
	`KTRS_ASSERT_IMPL(a_discord_range, m_axis_tvalid,
		m_axis_tdata[DISCORD_W-1:0] <= DISCORD_W'(MAX_PAIRS))
	`KTRS_ASSERT_NEXT(a_win_copies_pass, fire && won,
		(best_sum_q == sum_q) && (best_tally_q == tally_q) && (best_order_q == cand_order_q))

endmodule

`default_nettype wire

/* tb/sv/kendall_tau_rank_scorer_tb.sv */
// ----------------------------------------------------------------------------
// Kendall tau rank scorer testbench
// Drives candidate, voter, end-pass and clear-best words into the scorer under
// several item counts, predicts every result word from a behavioural score of
// the discordant pairs and the best candidate, and compares each field.
// ----------------------------------------------------------------------------
module kendall_tau_rank_scorer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ktrs_pkg::*;

	typedef logic [ORDER_W-1:0] order_t;

	typedef struct {
		logic [DISCORD_W-1:0] pair_discord;
		logic [SUM_W-1:0]     pass_discord_total;
		logic [TALLY_W-1:0]   pass_voters;
		logic                 became_best;
		logic [ORDER_W-1:0]   best_order;
		logic [SUM_W-1:0]     best_discord_total;
		logic [TALLY_W-1:0]   best_voters;
	} score_t;

	localparam int OFF_SUM = DISCORD_W;
	localparam int OFF_VOTERS = OFF_SUM + SUM_W;
	localparam int OFF_WON = OFF_VOTERS + TALLY_W;
	localparam int OFF_BORDER = OFF_WON + 1;
	localparam int OFF_BSUM = OFF_BORDER + ORDER_W;
	localparam int OFF_BVOTERS = OFF_BSUM + SUM_W;

	localparam logic [SUM_W-1:0] SUM_CAP = '1;
	localparam logic [TALLY_W-1:0] TALLY_CAP = '1;
	localparam int SETTLE_CYCLES = 6;
	localparam int LIMIT_CYCLES = 400000;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CNT_W-1:0]    cfg_wr_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [ORDER_W-1:0]  s_axis_tdata = '0;
	logic [1:0]          s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_W-1:0]    m_axis_tdata;

	// Behavioural copy of the scorer state.
	logic [CNT_W-1:0]    item_count_r = ITEM_COUNT_RESET;
	order_t              cand_order = '0;
	logic [SUM_W-1:0]    run_sum = '0;
	logic [TALLY_W-1:0]  run_voters = '0;
	bit                  best_valid = 1'b0;
	order_t              best_ord = '0;
	logic [SUM_W-1:0]    best_sum = '0;
	logic [TALLY_W-1:0]  best_tally = '0;

	score_t              pending_scores[$];
	int unsigned         error_count = 0;
	int unsigned         words_sent = 0;
	int unsigned         cycle_count = 0;
	bit                  tx_steady = 1'b0;
	bit                  rx_steady = 1'b0;
	int unsigned         rx_hold = 0;
	int unsigned         rx_stall = 0;

	kendall_tau_rank_scorer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(input string msg);
		error_count++;
		if (error_count <= 50) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	function automatic order_t ranks(input int unsigned a0, a1, a2, a3, a4, a5, a6, a7);
		return {a7[2:0], a6[2:0], a5[2:0], a4[2:0], a3[2:0], a2[2:0], a1[2:0], a0[2:0]};
	endfunction

	function automatic int unsigned active_items();
		return (item_count_r > 4'd8) ? 8 : int'(item_count_r);
	endfunction

	// Highest position below n that holds the item, or n when it is absent.
	function automatic int unsigned rank_of(input order_t o, input int unsigned n,
			input logic [2:0] item);
		int unsigned found;
		found = n;
		for (int unsigned p = 0; p < n; p++) begin
			if (o[3*p +: 3] == item) begin
				found = p;
			end
		end
		return found;
	endfunction

	function automatic int unsigned discordant_pairs(input order_t cand, input order_t voter,
			input int unsigned n);
		int unsigned total;
		int unsigned ca, cb, va, vb;
		total = 0;
		for (int unsigned i = 0; i + 1 < n; i++) begin
			for (int unsigned j = i + 1; j < n; j++) begin
				ca = rank_of(cand, n, cand[3*i +: 3]);
				cb = rank_of(cand, n, cand[3*j +: 3]);
				va = rank_of(voter, n, cand[3*i +: 3]);
				vb = rank_of(voter, n, cand[3*j +: 3]);
				if ((ca < cb && va > vb) || (ca > cb && va < vb)) begin
					total++;
				end
			end
		end
		return total;
	endfunction

	task automatic score_ranking(input opcode_t op, input order_t data);
		score_t s;
		int unsigned n, d;
		longint unsigned acc, lhs, rhs;
		n = active_items();
		d = 0;
		s.became_best = 1'b0;
		case (op)
			OP_LOAD: begin
				cand_order = '0;
				for (int unsigned i = 0; i < n; i++) begin
					cand_order[3*i +: 3] = data[3*i +: 3];
				end
				run_sum = '0;
				run_voters = '0;
			end
			OP_VOTER: begin
				d = discordant_pairs(cand_order, data, n);
				if (run_voters < TALLY_CAP) begin
					run_voters++;
					acc = run_sum;
					acc = acc + d;
					run_sum = (acc > SUM_CAP) ? SUM_CAP : acc[SUM_W-1:0];
				end
			end
			OP_END_PASS: begin
				lhs = run_sum;
				lhs = lhs * best_tally;
				rhs = best_sum;
				rhs = rhs * run_voters;
				if (run_voters != 0 && (!best_valid || lhs < rhs)) begin
					best_valid = 1'b1;
					best_ord = cand_order;
					best_sum = run_sum;
					best_tally = run_voters;
					s.became_best = 1'b1;
				end
			end
			default: begin
				best_valid = 1'b0;
				best_ord = '0;
				best_sum = '0;
				best_tally = '0;
			end
		endcase
		s.pair_discord = d[DISCORD_W-1:0];
		s.pass_discord_total = run_sum;
		s.pass_voters = run_voters;
		s.best_order = best_ord;
		s.best_discord_total = best_sum;
		s.best_voters = best_tally;
		pending_scores.push_back(s);
	endtask

	always @(posedge clk) begin : result_check
		score_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pair_discord = m_axis_tdata[0 +: DISCORD_W];
			got.pass_discord_total = m_axis_tdata[OFF_SUM +: SUM_W];
			got.pass_voters = m_axis_tdata[OFF_VOTERS +: TALLY_W];
			got.became_best = m_axis_tdata[OFF_WON];
			got.best_order = m_axis_tdata[OFF_BORDER +: ORDER_W];
			got.best_discord_total = m_axis_tdata[OFF_BSUM +: SUM_W];
			got.best_voters = m_axis_tdata[OFF_BVOTERS +: TALLY_W];
			if (pending_scores.size() == 0) begin
				report("result word arrived with nothing expected");
			end else begin
				want = pending_scores.pop_front();
				compare_field("pair_discord", got.pair_discord, want.pair_discord);
				compare_field("pass_discord_total", got.pass_discord_total,
					want.pass_discord_total);
				compare_field("pass_voters", got.pass_voters, want.pass_voters);
				compare_field("became_best", got.became_best, want.became_best);
				compare_field("best_order", got.best_order, want.best_order);
				compare_field("best_discord_total", got.best_discord_total,
					want.best_discord_total);
				compare_field("best_voters", got.best_voters, want.best_voters);
			end
		end
	end

	// The receiver holds off for whole stretches, counted down here.
	initial begin : receiver
		int unsigned r;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold--;
			end else if (rx_stall > 0) begin
				m_axis_tready <= 1'b0;
				rx_stall--;
			end else if (rx_steady) begin
				m_axis_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					rx_stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("kendall_tau_rank_scorer_tb NOT OK");
		$finish;
	end

	function automatic int unsigned tx_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 65) begin
			return 0;
		end
		return (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	task automatic pause_sender(input int unsigned cycles);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic offer_word(input opcode_t op, input order_t data);
		int unsigned gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		score_ranking(op, data);
		words_sent++;
		gap = tx_gap();
		if (gap > 0) begin
			pause_sender(gap);
		end
	endtask

	task automatic wait_idle();
		pause_sender(1);
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_item_count(input int unsigned value);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[CNT_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		item_count_r = value[CNT_W-1:0];
	endtask

	// A ranking of n distinct items drawn from 0..n-1, or from 0..7 when wide.
	function automatic order_t random_ranking(input int unsigned n, input bit wide);
		order_t o;
		int unsigned pool[8];
		int unsigned m, j, t;
		o = order_t'($urandom);
		m = wide ? 8 : n;
		for (int unsigned i = 0; i < 8; i++) begin
			pool[i] = i;
		end
		for (int unsigned i = m; i > 1; i--) begin
			j = $urandom_range(0, i - 1);
			t = pool[i-1];
			pool[i-1] = pool[j];
			pool[j] = t;
		end
		for (int unsigned i = 0; i < n; i++) begin
			o[3*i +: 3] = pool[i][2:0];
		end
		return o;
	endfunction

	function automatic order_t nearby_ranking(input order_t cand, input int unsigned n);
		order_t o;
		int unsigned p;
		logic [2:0] t;
		o = cand;
		if (n >= 2) begin
			repeat ($urandom_range(0, 3)) begin
				p = $urandom_range(0, n - 2);
				t = o[3*p +: 3];
				o[3*p +: 3] = o[3*(p+1) +: 3];
				o[3*(p+1) +: 3] = t;
			end
		end
		return o;
	endfunction

	task automatic run_pass_sequence();
		int unsigned n, r;
		order_t cand;
		n = active_items();
		if ($urandom_range(0, 99) < 80) begin
			if ($urandom_range(0, 9) == 0) begin
				offer_word(OP_CLEAR_BEST, order_t'($urandom));
			end
			cand = random_ranking(n, $urandom_range(0, 3) == 0);
			offer_word(OP_LOAD, cand);
			repeat ($urandom_range(1, 6)) begin
				r = $urandom_range(0, 9);
				if (r < 4) begin
					offer_word(OP_VOTER, random_ranking(n, r == 0));
				end else if (r < 9) begin
					offer_word(OP_VOTER, nearby_ranking(cand, n));
				end else begin
					offer_word(OP_VOTER, order_t'($urandom));
				end
			end
			offer_word(OP_END_PASS, order_t'($urandom));
			if ($urandom_range(0, 4) == 0) begin
				offer_word(OP_END_PASS, order_t'($urandom));
			end
		end else begin
			repeat ($urandom_range(1, 4)) begin
				offer_word(opcode_t'($urandom_range(0, 3)), order_t'($urandom));
			end
		end
	endtask

	task automatic run_traffic(input int unsigned count);
		int unsigned stop_at;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			run_pass_sequence();
		end
	endtask

	task automatic test_directed();
		offer_word(OP_VOTER, ranks(0, 1, 2, 3, 4, 5, 6, 7));
		offer_word(OP_END_PASS, '0);
		offer_word(OP_LOAD, ranks(0, 1, 2, 3, 4, 7, 7, 7));
		offer_word(OP_END_PASS, '0);
		offer_word(OP_VOTER, ranks(4, 3, 2, 1, 0, 0, 0, 0));
		offer_word(OP_VOTER, ranks(0, 1, 2, 3, 4, 7, 7, 7));
		offer_word(OP_END_PASS, '0);
		offer_word(OP_CLEAR_BEST, '0);
		offer_word(OP_END_PASS, '0);
		offer_word(OP_END_PASS, '0);
		offer_word(OP_LOAD, ranks(0, 1, 2, 3, 4, 0, 0, 0));
		offer_word(OP_VOTER, ranks(1, 3, 4, 0, 2, 0, 0, 0));
		offer_word(OP_END_PASS, '0);
		offer_word(OP_VOTER, ranks(0, 1, 2, 3, 4, 0, 0, 0));
		offer_word(OP_END_PASS, '0);
		offer_word(OP_LOAD, '1);
		offer_word(OP_VOTER, '1);
		offer_word(OP_LOAD, ranks(2, 1, 0, 3, 4, 0, 0, 0));
		offer_word(OP_VOTER, ranks(1, 1, 2, 2, 5, 0, 0, 0));
		offer_word(OP_VOTER, ranks(7, 6, 5, 4, 3, 2, 1, 0));
		offer_word(OP_END_PASS, '1);
		offer_word(OP_CLEAR_BEST, '1);
	endtask

	task automatic test_item_count_sweep();
		int unsigned sweep[11];
		sweep = '{8, 2, 3, 7, 0, 4, 6, 1, 9, 15, 5};
		foreach (sweep[k]) begin
			set_item_count(sweep[k]);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			run_traffic(110);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	task automatic test_receiver_holdoff();
		set_item_count(8);
		tx_steady = 1'b1;
		rx_hold = 150;
		run_traffic(60);
		tx_steady = 1'b0;
	endtask

	task automatic test_sender_pause();
		set_item_count(6);
		repeat (8) begin
			run_traffic(10);
			wait_idle();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_item_count_sweep();
		test_receiver_holdoff();
		test_sender_pause();
		wait_idle();
		if (error_count == 0 && pending_scores.size() == 0) begin
			$display("kendall_tau_rank_scorer_tb OK");
		end else begin
			$display("kendall_tau_rank_scorer_tb NOT OK");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ktrs_pkg.sv
rtl/ktrs_discord.sv
rtl/kendall_tau_rank_scorer.sv
tb/sv/kendall_tau_rank_scorer_tb.sv
